FILE: hdl/ufe_pkg.sv
// ----------------------------------------------------------------------------
// ufe_pkg: shared types and constants of the union-find engine
// Node width, command codes, the queued item format and the table depth rule.
// ----------------------------------------------------------------------------
package ufe_pkg;

  localparam int NODE_W    = 10;
  localparam int NODE_SPAN = 1 << NODE_W;

  // Command codes carried on the input channel
  localparam logic [1:0] CMD_FIND  = 2'd0;
  localparam logic [1:0] CMD_UNION = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  typedef logic [NODE_W-1:0] node_t;

  // Classified item as it travels from the front end to the back end
  typedef struct packed {
    logic  walk;    // find or union: walk both roots
    logic  link;    // union: link b's root under a's root
    logic  clear;   // reset the sets 1..node_count
    node_t node_a;
    node_t node_b;
    logic  a_in;    // node_a addresses a table entry
    logic  b_in;    // node_b addresses a table entry
  } ufe_item_t;

  // Only node numbers that fit the node field can ever reach the table
  function automatic int table_depth(input int nodes);
    return (nodes < NODE_SPAN) ? nodes : NODE_SPAN;
  endfunction

endpackage

FILE: hdl/ufe_if.sv
// ----------------------------------------------------------------------------
// ufe_if: channel interfaces of the union-find engine
// Valid/ready channels for command items and for result items.
// ----------------------------------------------------------------------------
interface ufe_in_if;
  import ufe_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] command;
  node_t      node_a;
  node_t      node_b;

  modport source (output valid, command, node_a, node_b, input ready);
  modport sink   (input valid, command, node_a, node_b, output ready);
endinterface

interface ufe_out_if;
  import ufe_pkg::*;

  logic  valid;
  logic  ready;
  node_t root_a;
  node_t root_b;
  logic  same_set;
  logic  merged;

  modport source (output valid, root_a, root_b, same_set, merged, input ready);
  modport sink   (input valid, root_a, root_b, same_set, merged, output ready);
endinterface

FILE: hdl/ufe_front.sv
// ----------------------------------------------------------------------------
// ufe_front: command intake of the union-find engine
// Accepts input transactions, classifies them and holds them in a short queue
// until the back end takes them.
// ----------------------------------------------------------------------------
module ufe_front #(
  parameter int NODES = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  ufe_in_if.sink            in_ch,
  output logic              q_valid,
  input  logic              q_pop,
  output ufe_pkg::ufe_item_t q_item
);
  import ufe_pkg::*;

  localparam int              DEPTH   = table_depth(NODES);
  localparam logic [NODE_W:0] DEPTH_X = (NODE_W+1)'(DEPTH);
  localparam logic [1:0]      QD      = 2'd2;

  ufe_item_t  item_in;
  ufe_item_t  slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic       pop;

  // Classify the incoming command
  always_comb begin
    item_in.walk   = (in_ch.command == CMD_FIND) || (in_ch.command == CMD_UNION);
    item_in.link   = (in_ch.command == CMD_UNION);
    item_in.clear  = (in_ch.command == CMD_CLEAR);
    item_in.node_a = in_ch.node_a;
    item_in.node_b = in_ch.node_b;
    item_in.a_in   = ({1'b0, in_ch.node_a} < DEPTH_X);
    item_in.b_in   = ({1'b0, in_ch.node_b} < DEPTH_X);
  end

  // Queue handshake
  assign in_ch.ready = (count_r != QD);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count_r != 2'd0);
  assign pop         = q_pop && q_valid;
  assign q_item      = slot_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the classified item
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

FILE: hdl/ufe_back.sv
// ----------------------------------------------------------------------------
// ufe_back: parent table and execution sequencer of the union-find engine
// Walks parent pointers, compresses paths, links roots, sweeps clears and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module ufe_back #(
  parameter int NODES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  ufe_pkg::ufe_item_t q_item,
  input  ufe_pkg::node_t     node_count,
  ufe_out_if.source          out_ch
);
  import ufe_pkg::*;

  localparam int              DEPTH   = table_depth(NODES);
  localparam int              IW      = $clog2(DEPTH);
  localparam logic [IW-1:0]   LAST    = IW'(DEPTH - 1);
  localparam logic [NODE_W:0] DEPTH_X = (NODE_W+1)'(DEPTH);

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_COMP  = 3'd4;
  localparam logic [2:0] ST_LINK  = 3'd5;
  localparam logic [2:0] ST_CLR   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  // Parent table
  node_t         mem [DEPTH];
  node_t         rd_data_r;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  node_t         mem_wdata;

  logic [2:0]    state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  ufe_item_t     item_r, item_nxt;
  logic          side_r, side_nxt;
  node_t         cur_r, cur_nxt;
  node_t         root_r, root_nxt;
  node_t         ra_r, ra_nxt;
  node_t         rb_r, rb_nxt;
  logic          same_r, same_nxt;
  logic          merged_r, merged_nxt;

  logic          out_valid_r;
  node_t         out_root_a_r;
  node_t         out_root_b_r;
  logic          out_same_r;
  logic          out_merged_r;
  logic          load_out;

  logic          side_done;
  node_t         found;
  node_t         side_node;
  logic          side_in;
  logic [IW-1:0] top_idx;
  logic          rb_in_tab;
  logic          rd_off_tab;

  // Node under work for the current side, clear limit, link guard
  assign side_node  = side_r ? item_r.node_b : item_r.node_a;
  assign side_in    = side_r ? item_r.b_in : item_r.a_in;
  assign top_idx    = (node_count > NODE_W'(DEPTH - 1)) ? LAST : node_count[IW-1:0];
  assign rb_in_tab  = ({1'b0, rb_r} < DEPTH_X);
  // A parent pointer outside the table ends the walk at the current node
  assign rd_off_tab = ({1'b0, rd_data_r} >= DEPTH_X);

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    item_nxt   = item_r;
    side_nxt   = side_r;
    cur_nxt    = cur_r;
    root_nxt   = root_r;
    ra_nxt     = ra_r;
    rb_nxt     = rb_r;
    same_nxt   = same_r;
    merged_nxt = merged_r;
    mem_we     = 1'b0;
    mem_waddr  = idx_r;
    mem_wdata  = NODE_W'(idx_r);
    rd_en      = 1'b0;
    rd_addr    = cur_r[IW-1:0];
    q_pop      = 1'b0;
    load_out   = 1'b0;
    side_done  = 1'b0;
    found      = root_r;

    case (state_r)
      // Sweep the table to identity after reset
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = NODE_W'(idx_r);
        if (idx_r == LAST) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end

      // Take the next item from the queue
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          item_nxt   = q_item;
          side_nxt   = 1'b0;
          ra_nxt     = '0;
          rb_nxt     = '0;
          same_nxt   = 1'b0;
          merged_nxt = 1'b0;
          if (q_item.clear) begin
            idx_nxt   = IW'(1);
            state_nxt = (top_idx == '0) ? ST_DONE : ST_CLR;
          end else if (q_item.walk) begin
            state_nxt = ST_START;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end

      // Begin a root walk, or take a node outside the table as its own root
      ST_START: begin
        if (!side_in) begin
          side_done = 1'b1;
          found     = side_node;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = side_node[IW-1:0];
          cur_nxt   = side_node;
          state_nxt = ST_WALK;
        end
      end

      // Follow parent pointers until a self-parent or a pointer outside the table shows up
      ST_WALK: begin
        if ((rd_data_r == cur_r) || rd_off_tab) begin
          root_nxt = cur_r;
          if (side_node == cur_r) begin
            side_done = 1'b1;
            found     = cur_r;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = side_node[IW-1:0];
            cur_nxt   = side_node;
            state_nxt = ST_COMP;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = rd_data_r[IW-1:0];
          cur_nxt = rd_data_r;
        end
      end

      // Rewrite each node on the path to point at the root
      ST_COMP: begin
        mem_we    = 1'b1;
        mem_waddr = cur_r[IW-1:0];
        mem_wdata = root_r;
        if (rd_data_r == root_r) begin
          side_done = 1'b1;
          found     = root_r;
        end else begin
          rd_en   = 1'b1;
          rd_addr = rd_data_r[IW-1:0];
          cur_nxt = rd_data_r;
        end
      end

      // Compare roots and link on union
      ST_LINK: begin
        same_nxt = (ra_r == rb_r);
        if (item_r.link && (ra_r != rb_r) && rb_in_tab) begin
          mem_we     = 1'b1;
          mem_waddr  = rb_r[IW-1:0];
          mem_wdata  = ra_r;
          merged_nxt = 1'b1;
        end
        state_nxt = ST_DONE;
      end

      // Sweep nodes 1..top back to their own roots
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = NODE_W'(idx_r);
        if (idx_r == top_idx) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end

      // Hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Close one side: a goes on to b, b goes on to the link step
    if (side_done) begin
      if (!side_r) begin
        ra_nxt    = found;
        side_nxt  = 1'b1;
        state_nxt = ST_START;
      end else begin
        rb_nxt    = found;
        state_nxt = ST_LINK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    side_r   <= side_nxt;
    cur_r    <= cur_nxt;
    root_r   <= root_nxt;
    ra_r     <= ra_nxt;
    rb_r     <= rb_nxt;
    same_r   <= same_nxt;
    merged_r <= merged_nxt;
  end

  // Table write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Output register: hold until the transaction completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_root_a_r <= ra_r;
      out_root_b_r <= rb_r;
      out_same_r   <= same_r;
      out_merged_r <= merged_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.root_a   = out_root_a_r;
  assign out_ch.root_b   = out_root_b_r;
  assign out_ch.same_set = out_same_r;
  assign out_ch.merged   = out_merged_r;

`ifndef NO_ASSERTIONS
  a_merge_excludes_same: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_merged_r) |-> !out_same_r)
    else $error("merged result reports both nodes in the same set");

  a_comp_not_root: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMP) |-> (cur_r != root_r))
    else $error("path compression reached the root itself");

  a_walk_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK || state_r == ST_COMP) |-> $past(rd_en))
    else $error("walk step without a table read in the previous cycle");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result presented outside the done step");
`endif

endmodule

FILE: hdl/union_find_engine_unit.sv
// ----------------------------------------------------------------------------
// union_find_engine_unit: disjoint-set engine with path compression
// Top level: node count register, command front end and execution back end.
// ----------------------------------------------------------------------------
// After reset the engine sets every table entry to its own index and
// executes no command until then, though the front end may queue up to two;
// configuration writes are taken throughout. Commands are queued two deep
// and executed one at a time against a single parent table with one read
// and one write port, one pointer step per cycle. A find or union passes
// through intake, a root walk with path compression where needed for each
// of its two nodes (a node outside the table is taken as its own root), the
// link step and the hand-off; a clear sets table entries 1 to min(node_count,
// NODES-1) back to their own index, one table entry per cycle. Each command
// returns exactly one result transaction, and the next command starts while
// a finished result waits to be taken.
module union_find_engine_unit #(
  parameter int NODES = 1024
) (
  input  logic           clk,
  input  logic           rst_n,
  ufe_in_if.sink         in_ch,
  ufe_out_if.source      out_ch,
  input  logic           cfg_we,
  input  ufe_pkg::node_t cfg_wdata
);
  import ufe_pkg::*;

  localparam node_t COUNT_RESET = NODE_W'(NODE_SPAN - 1);

  node_t     node_count_r;
  logic      q_valid;
  logic      q_pop;
  ufe_item_t q_item;

  // Node count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= COUNT_RESET;
    end else if (cfg_we) begin
      node_count_r <= cfg_wdata;
    end
  end

  ufe_front #(
    .NODES (NODES)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_item  (q_item)
  );

  ufe_back #(
    .NODES (NODES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item),
    .node_count (node_count_r),
    .out_ch     (out_ch)
  );

endmodule

FILE: bench/union_find_engine_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// union_find_engine_unit_tb: self-checking bench for the union-find engine
// Drives find, union, clear and unused commands through the command channel
// and keeps its own parent table with path compression. Every result
// transaction is checked against the roots predicted for the oldest accepted
// command. Clear bounds are changed between phases, and both sides stall.
// ----------------------------------------------------------------------------
module union_find_engine_unit_tb;
  import ufe_pkg::*;

  localparam int TB_NODES    = 1024;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE      = 24;
  localparam int PHASE_ITEMS = 233;

  // Command code with no operation behind it
  localparam logic [1:0] CMD_NOP = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    node_t      node_a;
    node_t      node_b;
  } uf_cmd_t;

  typedef struct packed {
    node_t root_a;
    node_t root_b;
    logic  same_set;
    logic  merged;
  } root_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  node_t cfg_wdata = '0;

  logic drv_valid = 1'b0;
  uf_cmd_t drv_cmd = '0;
  logic mon_ready = 1'b0;

  ufe_in_if  in_ch ();
  ufe_out_if out_ch ();

  assign in_ch.valid   = drv_valid;
  assign in_ch.command = drv_cmd.command;
  assign in_ch.node_a  = drv_cmd.node_a;
  assign in_ch.node_b  = drv_cmd.node_b;
  assign out_ch.ready  = mon_ready;

  union_find_engine_unit #(
    .NODES(TB_NODES)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // Shadow state of the engine
  node_t link_table [TB_NODES];
  node_t clear_top;

  uf_cmd_t      cmd_q [$];
  root_result_t expected_roots [$];
  int           fail_cnt = 0;

  // Driver and monitor bookkeeping
  uf_cmd_t cur_cmd = '0;
  bit      have_item = 1'b0;
  bit      showing = 1'b0;
  int      drv_gap = 0;
  bit      drv_burst = 1'b0;
  int      mon_gap = 0;
  bit      mon_burst = 1'b0;
  int      idle_cycles = 0;

  // Draw the wait before the next transaction; flip between bursts and gaps
  function automatic int draw_gap(inout bit burst);
    if ($urandom_range(0, 39) == 0) burst = ~burst;
    return burst ? 0 : int'($urandom_range(0, 18));
  endfunction

  // Walk to the root, then point every node on the path straight at it
  function automatic node_t chase_root(input node_t node);
    node_t root;
    node_t cur;
    node_t nxt;
    int    steps;
    if (int'(node) >= TB_NODES) return node;
    root = node;
    for (steps = 0; steps < TB_NODES; steps++) begin
      nxt = link_table[root];
      if (nxt == root || int'(nxt) >= TB_NODES) break;
      root = nxt;
    end
    cur = node;
    for (steps = 0; steps < TB_NODES && cur != root; steps++) begin
      nxt = link_table[cur];
      link_table[cur] = root;
      if (int'(nxt) >= TB_NODES) break;
      cur = nxt;
    end
    return root;
  endfunction

  // Apply one command to the shadow table and return its result
  function automatic root_result_t union_find_step(input uf_cmd_t it);
    root_result_t r;
    int top;
    r = '0;
    if (it.command == CMD_CLEAR) begin
      top = int'(clear_top);
      if (top > TB_NODES - 1) top = TB_NODES - 1;
      for (int i = 1; i <= top; i++) link_table[i] = node_t'(i);
    end else if (it.command == CMD_FIND || it.command == CMD_UNION) begin
      r.root_a   = chase_root(it.node_a);
      r.root_b   = chase_root(it.node_b);
      r.same_set = (r.root_a == r.root_b);
      if (it.command == CMD_UNION && !r.same_set && int'(r.root_b) < TB_NODES) begin
        link_table[r.root_b] = r.root_a;
        r.merged = 1'b1;
      end
    end
    return r;
  endfunction

  // Command driver: present queued items, predict each accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && in_ch.ready) begin
        expected_roots.push_back(union_find_step(cur_cmd));
        have_item = 1'b0;
        showing = 1'b0;
      end
      if (!have_item && cmd_q.size() != 0) begin
        cur_cmd = cmd_q.pop_front();
        have_item = 1'b1;
        drv_gap = draw_gap(drv_burst);
      end
      if (have_item && !showing) begin
        if (drv_gap == 0) showing = 1'b1;
        else drv_gap--;
      end
      drv_valid <= showing;
      drv_cmd <= cur_cmd;
    end
  end

  // Result monitor: stall at random, compare each transaction with the oldest prediction
  always @(posedge clk) begin : result_monitor
    root_result_t got;
    root_result_t want;
    if (!rst_n) begin
      mon_ready <= 1'b0;
    end else begin
      if (out_ch.valid && mon_ready) begin
        got.root_a   = out_ch.root_a;
        got.root_b   = out_ch.root_b;
        got.same_set = out_ch.same_set;
        got.merged   = out_ch.merged;
        if (expected_roots.size() == 0) begin
          fail_cnt++;
          $display("%0t: result with nothing expected: root_a=%0d root_b=%0d same=%0b merged=%0b",
                   $time, got.root_a, got.root_b, got.same_set, got.merged);
        end else begin
          want = expected_roots.pop_front();
          if (got !== want) begin
            fail_cnt++;
            $display("%0t: mismatch expected root_a=%0d root_b=%0d same=%0b merged=%0b",
                     $time, want.root_a, want.root_b, want.same_set, want.merged);
            $display("%0t:          actual   root_a=%0d root_b=%0d same=%0b merged=%0b",
                     $time, got.root_a, got.root_b, got.same_set, got.merged);
          end
        end
        mon_gap = draw_gap(mon_burst);
      end
      if (mon_gap > 0) begin
        mon_gap--;
        mon_ready <= 1'b0;
      end else begin
        mon_ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic queue_cmd(input logic [1:0] command, input int a, input int b);
    uf_cmd_t it;
    it.command = command;
    it.node_a = node_t'(a);
    it.node_b = node_t'(b);
    cmd_q.push_back(it);
  endtask

  // Hold until every queued item has been taken and every result has come
  task automatic wait_drained();
    @(negedge clk);
    while (cmd_q.size() != 0 || have_item || expected_roots.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_clear_top(input node_t value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    clear_top = value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly unions and finds inside a small window so that sets grow deep
  task automatic queue_random(input int count);
    int pick;
    int base;
    int span;
    uf_cmd_t it;
    base = 0;
    span = 8;
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: span = 8;
          1: span = 32;
          default: span = 64;
        endcase
        case ($urandom_range(0, 3))
          0: base = 0;
          1: base = TB_NODES - span;
          default: base = $urandom_range(0, TB_NODES - span);
        endcase
      end
      pick = $urandom_range(0, 99);
      it.node_a = node_t'($urandom_range(0, TB_NODES - 1));
      it.node_b = node_t'($urandom_range(0, TB_NODES - 1));
      if (pick < 3) begin
        it.command = CMD_CLEAR;
      end else if (pick < 5) begin
        it.command = CMD_NOP;
      end else if (pick < 12) begin
        it.command = ($urandom_range(0, 1) == 0) ? CMD_FIND : CMD_UNION;
      end else begin
        it.command = (pick < 60) ? CMD_UNION : CMD_FIND;
        it.node_a = node_t'(base + $urandom_range(0, span - 1));
        it.node_b = node_t'(base + $urandom_range(0, span - 1));
      end
      cmd_q.push_back(it);
    end
  endtask

  // Stimulus: reset, directed cases, then random phases under several clear bounds
  initial begin
    node_t bounds [7];
    for (int i = 0; i < TB_NODES; i++) link_table[i] = node_t'(i);
    clear_top = node_t'(1023);
    bounds[0] = node_t'(5);
    bounds[1] = node_t'(0);
    bounds[2] = node_t'(1023);
    bounds[3] = node_t'($urandom_range(1, 1022));
    bounds[4] = node_t'(1);
    bounds[5] = node_t'($urandom_range(1, 1022));
    bounds[6] = node_t'(512);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    set_clear_top(node_t'(1023));

    // Extremes of the node numbers, fresh table
    queue_cmd(CMD_FIND, 0, 0);
    queue_cmd(CMD_FIND, 1023, 1023);
    queue_cmd(CMD_FIND, 0, 1023);
    // Link, link through a non-root, union of one set
    queue_cmd(CMD_UNION, 1, 2);
    queue_cmd(CMD_UNION, 2, 3);
    queue_cmd(CMD_UNION, 1, 3);
    queue_cmd(CMD_FIND, 3, 2);
    // Build a chain, then compress it with one find
    queue_cmd(CMD_UNION, 10, 11);
    queue_cmd(CMD_UNION, 12, 10);
    queue_cmd(CMD_UNION, 13, 12);
    queue_cmd(CMD_UNION, 14, 13);
    queue_cmd(CMD_FIND, 11, 14);
    queue_cmd(CMD_UNION, 7, 7);
    queue_cmd(CMD_UNION, 0, 1023);
    queue_cmd(CMD_UNION, 1023, 5);
    queue_cmd(CMD_UNION, 682, 341);
    // Unused command code: no change, zero result
    queue_cmd(CMD_NOP, 1023, 0);
    queue_cmd(CMD_NOP, 5, 6);
    // Node zero linked away survives a clear
    queue_cmd(CMD_UNION, 9, 0);
    queue_cmd(CMD_CLEAR, 1023, 1023);
    queue_cmd(CMD_FIND, 0, 9);
    queue_cmd(CMD_FIND, 1023, 5);
    queue_cmd(CMD_FIND, 341, 682);

    for (int p = 0; p < 7; p++) begin
      wait_drained();
      set_clear_top(bounds[p]);
      queue_random(PHASE_ITEMS);
    end

    wait_drained();
    if (fail_cnt == 0 && expected_roots.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/ufe_pkg.sv
hdl/ufe_if.sv
hdl/ufe_front.sv
hdl/ufe_back.sv
hdl/union_find_engine_unit.sv
bench/union_find_engine_unit_tb.sv
